[rtl/acoustic_upwind_face_flux_defines.svh]
// Assertion macros for the acoustic upwind face flux block.
// Included by the RTL files that carry concurrent assertions; needs i_clk and i_rst_n in scope.
`ifndef ACOUSTIC_UPWIND_FACE_FLUX_DEFINES_SVH
`define ACOUSTIC_UPWIND_FACE_FLUX_DEFINES_SVH
`ifndef SYNTH
`define AUF_ASSERT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("acoustic_upwind_face_flux: assertion failed");
`define AUF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("acoustic_upwind_face_flux: assertion failed");
`else
`define AUF_ASSERT(label, ante, cons)
`define AUF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/auf_pkg.sv]
// Package for the acoustic upwind face flux block: pipeline sizes, divider lane type,
// the restoring divider step and the Q16.16 output saturation. No dependencies.
package auf_pkg;

    localparam int DIV_STEPS  = 44;
    localparam int REM_W      = 34;
    localparam int DEN_W      = 33;
    localparam int PIPE_DEPTH = 12 + DIV_STEPS + 1;

    typedef logic [REM_W-1:0]     t_rem;
    typedef logic [DIV_STEPS-1:0] t_quo;

    typedef struct packed {
        t_rem rem;
        t_quo w;
        logic ovf;
    } t_div_lane;

    function automatic t_div_lane f_div_lane(t_div_lane cur, logic [DEN_W-1:0] den);
        t_div_lane nxt;
        t_rem      sh;
        sh      = {cur.rem[REM_W-2:0], cur.w[DIV_STEPS-1]};
        nxt.ovf = cur.ovf;
        if (sh >= REM_W'(den)) begin
            nxt.rem = sh - REM_W'(den);
            nxt.w   = {cur.w[DIV_STEPS-2:0], 1'b1};
        end else begin
            nxt.rem = sh;
            nxt.w   = {cur.w[DIV_STEPS-2:0], 1'b0};
        end
        return nxt;
    endfunction

    function automatic logic [31:0] f_sat(logic neg, logic [47:0] mag);
        if (neg) begin
            if (mag > 48'h0000_8000_0000) begin
                return 32'h8000_0000;
            end
            return 32'd0 - mag[31:0];
        end
        if (mag > 48'h0000_7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end
        return mag[31:0];
    endfunction

endpackage

[rtl/acoustic_upwind_face_flux.sv]
// Top level of the acoustic upwind face flux block: a fully pipelined fixed point datapath.
// Depends on auf_pkg and acoustic_upwind_face_flux_defines.svh.
`include "acoustic_upwind_face_flux_defines.svh"

// Computes the upwind penalty fluxes of one face node per request and accepts a new request
// in every cycle unless the output stalls. The depth of the pipeline is set by two
// 44-step restoring dividers that run side by side, one quotient bit per stage. A stalled
// result freezes the whole pipeline, so the input stalls only while the output does.
module acoustic_upwind_face_flux (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_pressure_minus,
    input  logic        [47:0] i_velocity_minus_xyz,
    input  logic signed [15:0] i_pressure_plus,
    input  logic        [47:0] i_velocity_plus_xyz,
    input  logic        [47:0] i_normal_xyz,
    input  logic        [15:0] i_speed_here,
    input  logic        [15:0] i_density_here,
    input  logic        [15:0] i_speed_neighbour,
    input  logic        [15:0] i_density_neighbour,
    input  logic               i_has_neighbour,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pressure_flux,
    output logic signed [31:0] o_flux_x,
    output logic signed [31:0] o_flux_y,
    output logic signed [31:0] o_flux_z
);
    import auf_pkg::*;

    logic                  adv;
    logic [PIPE_DEPTH-1:0] r_vld;

    logic signed [16:0] n1_dv [3];
    logic signed [32:0] n1_dprod [3];
    logic signed [29:0] n1_dp;
    logic signed [32:0] r1_dprod [3];
    logic signed [29:0] r1_dp;
    logic        [31:0] r1_z, r1_zp;
    logic        [15:0] r1_c;
    logic               r1_inner;
    logic        [47:0] r1_nrm;

    logic signed [34:0] r2_du;
    logic        [32:0] r2_s;
    logic        [47:0] r2_cz;
    logic        [31:0] r2_zp;
    logic        [15:0] r2_c;
    logic signed [29:0] r2_dp;
    logic        [47:0] r2_nrm;

    logic        [32:0] r3_dumag;
    logic               r3_duneg;
    logic        [32:0] r3_s;
    logic        [47:0] r3_cz;
    logic        [31:0] r3_zp;
    logic        [15:0] r3_c;
    logic signed [29:0] r3_dp;
    logic        [47:0] r3_nrm;

    logic        [47:0] r4_tlo;
    logic        [48:0] r4_thi;
    logic               r4_duneg;
    logic        [32:0] r4_s;
    logic        [47:0] r4_cz;
    logic        [15:0] r4_c;
    logic signed [29:0] r4_dp;
    logic        [47:0] r4_nrm;

    logic        [49:0] r5_t;
    logic               r5_duneg;
    logic        [32:0] r5_s;
    logic        [47:0] r5_cz;
    logic        [15:0] r5_c;
    logic signed [29:0] r5_dp;
    logic        [47:0] r5_nrm;

    logic signed [51:0] n6_t;
    logic signed [51:0] r6_a;
    logic        [32:0] r6_s;
    logic        [47:0] r6_cz;
    logic        [15:0] r6_c;
    logic        [47:0] r6_nrm;

    logic        [49:0] r7_amag;
    logic               r7_aneg;
    logic        [32:0] r7_s;
    logic        [47:0] r7_cz;
    logic        [15:0] r7_c;
    logic        [47:0] r7_nrm;

    logic        [40:0] r8_pl, r8_ph;
    logic        [48:0] r8_q00, r8_q01, r8_q10, r8_q11;
    logic               r8_aneg;
    logic        [32:0] r8_s;
    logic        [47:0] r8_nrm;

    logic        [65:0] r9_np;
    logic        [73:0] r9_s0, r9_s1;
    logic               r9_aneg;
    logic        [32:0] r9_s;
    logic        [47:0] r9_nrm;

    logic        [97:0] n10_full;
    logic        [81:0] r10_nq;
    logic        [65:0] r10_np;
    logic               r10_aneg;
    logic        [32:0] r10_s;
    logic        [47:0] r10_nrm;

    t_div_lane          n_dv_p0, n_dv_q0;
    t_div_lane          r_dv_p [DIV_STEPS+1];
    t_div_lane          r_dv_q [DIV_STEPS+1];
    logic  [DEN_W-1:0]  r_dv_s [DIV_STEPS+1];
    logic               r_dv_aneg [DIV_STEPS+1];
    logic               r_dv_sz [DIV_STEPS+1];
    logic        [47:0] r_dv_nrm [DIV_STEPS+1];

    t_div_lane          pa_pen, pa_prs;
    logic        [15:0] pa_nk [3];
    logic        [15:0] pa_nmag [3];
    logic        [31:0] n_pa_pf;
    logic        [31:0] r_pa_pf;
    logic        [37:0] r_pa_lo [3];
    logic        [37:0] r_pa_hi [3];
    logic               r_pa_fneg [3];
    logic               r_pa_big [3];
    logic               r_pa_sz;

    logic        [59:0] pb_full [3];
    logic        [31:0] n_o_fx [3];
    logic        [31:0] r_o_pf;
    logic        [31:0] r_o_fx [3];

    assign adv     = !(r_vld[PIPE_DEPTH-1] && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n1_dv[k]    = 17'($signed(i_velocity_plus_xyz[16*k +: 16]))
                        - 17'($signed(i_velocity_minus_xyz[16*k +: 16]));
            n1_dprod[k] = $signed(i_normal_xyz[16*k +: 16]) * n1_dv[k];
        end
        if (i_has_neighbour) begin
            n1_dp = (30'(i_pressure_plus) - 30'(i_pressure_minus)) <<< 12;
        end else begin
            n1_dp = 30'sd0 - (30'(i_pressure_minus) <<< 13);
        end
        n6_t     = signed'({2'b00, r5_t});
        n10_full = 98'(r9_s0) + (98'(r9_s1) << 24);
        n_dv_p0.ovf = {11'd0, r10_np[65:44]} >= r10_s;
        n_dv_p0.rem = REM_W'(r10_np[65:44]);
        n_dv_p0.w   = r10_np[43:0];
        n_dv_q0.ovf = r10_nq[81:44] >= {5'd0, r10_s};
        n_dv_q0.rem = r10_nq[77:44];
        n_dv_q0.w   = r10_nq[43:0];
    end

    always_comb begin
        pa_pen  = r_dv_p[DIV_STEPS];
        pa_prs  = r_dv_q[DIV_STEPS];
        n_pa_pf = r_dv_sz[DIV_STEPS] ? 32'd0
                : f_sat(!r_dv_aneg[DIV_STEPS], pa_prs.ovf ? '1 : 48'(pa_prs.w));
        for (int k = 0; k < 3; k++) begin
            pa_nk[k]   = r_dv_nrm[DIV_STEPS][16*k +: 16];
            pa_nmag[k] = pa_nk[k][15] ? 16'd0 - pa_nk[k] : pa_nk[k];
            pb_full[k] = 60'(r_pa_lo[k]) + (60'(r_pa_hi[k]) << 22);
            n_o_fx[k]  = r_pa_sz ? 32'd0
                       : f_sat(r_pa_fneg[k], r_pa_big[k] ? '1 : pb_full[k][59:12]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_dprod <= n1_dprod;
            r1_dp    <= n1_dp;
            r1_z     <= i_density_here * i_speed_here;
            r1_zp    <= i_density_neighbour * i_speed_neighbour;
            r1_c     <= i_speed_here;
            r1_inner <= i_has_neighbour;
            r1_nrm   <= i_normal_xyz;

            r2_du  <= r1_inner ? 35'(r1_dprod[0]) + 35'(r1_dprod[1]) + 35'(r1_dprod[2]) : '0;
            r2_s   <= {1'b0, r1_z} + {1'b0, r1_zp};
            r2_cz  <= r1_c * r1_z;
            r2_zp  <= r1_zp;
            r2_c   <= r1_c;
            r2_dp  <= r1_dp;
            r2_nrm <= r1_nrm;

            r3_dumag <= 33'(r2_du[34] ? -r2_du : r2_du);
            r3_duneg <= r2_du[34];
            r3_s     <= r2_s;
            r3_cz    <= r2_cz;
            r3_zp    <= r2_zp;
            r3_c     <= r2_c;
            r3_dp    <= r2_dp;
            r3_nrm   <= r2_nrm;

            r4_tlo   <= r3_zp * r3_dumag[15:0];
            r4_thi   <= r3_zp * r3_dumag[32:16];
            r4_duneg <= r3_duneg;
            r4_s     <= r3_s;
            r4_cz    <= r3_cz;
            r4_c     <= r3_c;
            r4_dp    <= r3_dp;
            r4_nrm   <= r3_nrm;

            r5_t     <= 50'(r4_thi) + 50'(r4_tlo[47:16]);
            r5_duneg <= r4_duneg;
            r5_s     <= r4_s;
            r5_cz    <= r4_cz;
            r5_c     <= r4_c;
            r5_dp    <= r4_dp;
            r5_nrm   <= r4_nrm;

            r6_a   <= r5_duneg ? 52'(r5_dp) + n6_t : 52'(r5_dp) - n6_t;
            r6_s   <= r5_s;
            r6_cz  <= r5_cz;
            r6_c   <= r5_c;
            r6_nrm <= r5_nrm;

            r7_amag <= 50'(r6_a[51] ? -r6_a : r6_a);
            r7_aneg <= r6_a[51];
            r7_s    <= r6_s;
            r7_cz   <= r6_cz;
            r7_c    <= r6_c;
            r7_nrm  <= r6_nrm;

            r8_pl   <= r7_c * r7_amag[24:0];
            r8_ph   <= r7_c * r7_amag[49:25];
            r8_q00  <= r7_cz[23:0] * r7_amag[24:0];
            r8_q01  <= r7_cz[23:0] * r7_amag[49:25];
            r8_q10  <= r7_cz[47:24] * r7_amag[24:0];
            r8_q11  <= r7_cz[47:24] * r7_amag[49:25];
            r8_aneg <= r7_aneg;
            r8_s    <= r7_s;
            r8_nrm  <= r7_nrm;

            r9_np   <= 66'(r8_pl) + (66'(r8_ph) << 25);
            r9_s0   <= 74'(r8_q00) + (74'(r8_q01) << 25);
            r9_s1   <= 74'(r8_q10) + (74'(r8_q11) << 25);
            r9_aneg <= r8_aneg;
            r9_s    <= r8_s;
            r9_nrm  <= r8_nrm;

            r10_nq   <= n10_full[97:16];
            r10_np   <= r9_np;
            r10_aneg <= r9_aneg;
            r10_s    <= r9_s;
            r10_nrm  <= r9_nrm;

            r_dv_p[0]    <= n_dv_p0;
            r_dv_q[0]    <= n_dv_q0;
            r_dv_s[0]    <= r10_s;
            r_dv_aneg[0] <= r10_aneg;
            r_dv_sz[0]   <= (r10_s == '0);
            r_dv_nrm[0]  <= r10_nrm;
            for (int j = 1; j <= DIV_STEPS; j++) begin
                r_dv_p[j]    <= f_div_lane(r_dv_p[j-1], r_dv_s[j-1]);
                r_dv_q[j]    <= f_div_lane(r_dv_q[j-1], r_dv_s[j-1]);
                r_dv_s[j]    <= r_dv_s[j-1];
                r_dv_aneg[j] <= r_dv_aneg[j-1];
                r_dv_sz[j]   <= r_dv_sz[j-1];
                r_dv_nrm[j]  <= r_dv_nrm[j-1];
            end

            r_pa_pf <= n_pa_pf;
            r_pa_sz <= r_dv_sz[DIV_STEPS];
            for (int k = 0; k < 3; k++) begin
                r_pa_lo[k]   <= pa_nmag[k] * pa_pen.w[21:0];
                r_pa_hi[k]   <= pa_nmag[k] * pa_pen.w[43:22];
                r_pa_fneg[k] <= pa_nk[k][15] ^ r_dv_aneg[DIV_STEPS];
                r_pa_big[k]  <= pa_pen.ovf && (pa_nmag[k] != 16'd0);
            end

            r_o_pf <= r_pa_pf;
            r_o_fx <= n_o_fx;
        end
    end

    assign o_pressure_flux = r_o_pf;
    assign o_flux_x        = r_o_fx[0];
    assign o_flux_y        = r_o_fx[1];
    assign o_flux_z        = r_o_fx[2];

    `AUF_ASSERT_NEXT(a_freeze, o_stall, $stable(r_vld))
    `AUF_ASSERT(a_pen_rem, r_vld[PIPE_DEPTH-3] && !r_dv_p[DIV_STEPS].ovf && !r_dv_sz[DIV_STEPS], (r_dv_p[DIV_STEPS].rem < REM_W'(r_dv_s[DIV_STEPS])))
    `AUF_ASSERT(a_prs_rem, r_vld[PIPE_DEPTH-3] && !r_dv_q[DIV_STEPS].ovf && !r_dv_sz[DIV_STEPS], (r_dv_q[DIV_STEPS].rem < REM_W'(r_dv_s[DIV_STEPS])))

endmodule

[bench/tb_top.sv]
// Self-checking testbench for acoustic_upwind_face_flux: directed and random face nodes.
// A local fixed point predictor of the upwind fluxes feeds a queue checked against each result.
// Depends only on the RTL top level acoustic_upwind_face_flux.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] p_minus;
        logic        [47:0] u_minus;
        logic signed [15:0] p_plus;
        logic        [47:0] u_plus;
        logic        [47:0] normal;
        logic        [15:0] c_here;
        logic        [15:0] rho_here;
        logic        [15:0] c_nb;
        logic        [15:0] rho_nb;
        logic               interior;
    } t_face;

    typedef struct {
        logic signed [31:0] p_flux;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
    } t_flux;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_pressure_minus;
    logic        [47:0] i_velocity_minus_xyz;
    logic signed [15:0] i_pressure_plus;
    logic        [47:0] i_velocity_plus_xyz;
    logic        [47:0] i_normal_xyz;
    logic        [15:0] i_speed_here;
    logic        [15:0] i_density_here;
    logic        [15:0] i_speed_neighbour;
    logic        [15:0] i_density_neighbour;
    logic               i_has_neighbour;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_pressure_flux;
    logic signed [31:0] o_flux_x;
    logic signed [31:0] o_flux_y;
    logic signed [31:0] o_flux_z;

    t_flux flux_queue[$];
    int    mismatches;
    int    send_idle_pct;
    int    recv_idle_pct;

    acoustic_upwind_face_flux u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] sat_q16(logic neg, logic [127:0] m);
        if (neg) begin
            if (m > 128'h8000_0000) begin
                return 32'h8000_0000;
            end
            return 32'd0 - m[31:0];
        end
        if (m > 128'h7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end
        return m[31:0];
    endfunction

    function automatic longint normal_dot(logic [47:0] n, logic [47:0] u);
        longint acc;
        acc = 0;
        for (int k = 0; k < 3; k++) begin
            acc += longint'($signed(n[16*k +: 16])) * longint'($signed(u[16*k +: 16]));
        end
        return acc;
    endfunction

    function automatic t_flux upwind_flux(t_face f);
        t_flux        r;
        logic [127:0] z, zp, s, c, t, amag, q, penm, m;
        longint       dp, du, a, nk;
        logic         aneg;
        c  = 128'(f.c_here);
        z  = 128'(f.rho_here) * c;
        zp = 128'(f.rho_nb) * 128'(f.c_nb);
        s  = z + zp;
        r  = '{default: '0};
        if (s == 0) begin
            return r;
        end
        if (f.interior) begin
            dp = (longint'(f.p_plus) - longint'(f.p_minus)) * 4096;
            du = normal_dot(f.normal, f.u_plus) - normal_dot(f.normal, f.u_minus);
        end else begin
            dp = -2 * longint'(f.p_minus) * 4096;
            du = 0;
        end
        t = (zp * 128'(du < 0 ? -du : du)) / 65536;
        if (t > (128'd1 << 52)) begin
            t = 128'd1 << 52;
        end
        a    = du < 0 ? dp + longint'(t) : dp - longint'(t);
        aneg = a < 0;
        amag = 128'(a < 0 ? -a : a);
        q = (c * z * amag) / (s << 16);
        if (q > (128'd1 << 32)) begin
            q = 128'd1 << 32;
        end
        r.p_flux = sat_q16(!aneg && amag != 0, q);
        penm = (c * amag) / s;
        if (penm > (128'd1 << 47)) begin
            penm = 128'd1 << 47;
        end
        for (int k = 0; k < 3; k++) begin
            nk = longint'($signed(f.normal[16*k +: 16]));
            m  = (128'(nk < 0 ? -nk : nk) * penm) >> 12;
            case (k)
                0: r.fx = sat_q16((nk < 0) != aneg && m != 0, m);
                1: r.fy = sat_q16((nk < 0) != aneg && m != 0, m);
                default: r.fz = sat_q16((nk < 0) != aneg && m != 0, m);
            endcase
        end
        return r;
    endfunction

    task automatic send_face(t_face f);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid              <= 1'b1;
        i_pressure_minus     <= f.p_minus;
        i_velocity_minus_xyz <= f.u_minus;
        i_pressure_plus      <= f.p_plus;
        i_velocity_plus_xyz  <= f.u_plus;
        i_normal_xyz         <= f.normal;
        i_speed_here         <= f.c_here;
        i_density_here       <= f.rho_here;
        i_speed_neighbour    <= f.c_nb;
        i_density_neighbour  <= f.rho_nb;
        i_has_neighbour      <= f.interior;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        flux_queue.push_back(upwind_flux(f));
    endtask

    function automatic logic [15:0] rand_medium();
        case ($urandom_range(5))
            0: return 16'd1;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(65535, 1));
            default: return 16'($urandom_range(1024, 64));
        endcase
    endfunction

    function automatic logic [47:0] rand_vec(bit unit_like);
        logic [47:0] v;
        for (int k = 0; k < 3; k++) begin
            if (unit_like) begin
                v[16*k +: 16] = 16'($signed($urandom_range(8192)) - 4096);
            end else begin
                v[16*k +: 16] = 16'($urandom);
            end
        end
        return v;
    endfunction

    function automatic t_face rand_face();
        t_face f;
        bit    tame;
        tame       = $urandom_range(3) != 0;
        f.p_minus  = tame ? 16'($signed($urandom_range(4096)) - 2048) : 16'($urandom);
        f.p_plus   = tame ? 16'($signed($urandom_range(4096)) - 2048) : 16'($urandom);
        f.u_minus  = rand_vec(tame);
        f.u_plus   = rand_vec(tame);
        f.normal   = rand_vec($urandom_range(2) != 0);
        f.c_here   = rand_medium();
        f.rho_here = rand_medium();
        f.c_nb     = rand_medium();
        f.rho_nb   = rand_medium();
        f.interior = $urandom_range(3) != 0;
        return f;
    endfunction

    task automatic test_extremes();
        t_face f;
        logic [15:0] pv[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        for (int i = 0; i < 16; i++) begin
            f.p_minus  = pv[i % 4];
            f.p_plus   = pv[(i / 4) % 4];
            f.u_minus  = {3{pv[(i + 1) % 4]}};
            f.u_plus   = {3{pv[(i + 2) % 4]}};
            f.normal   = {3{pv[(i + 3) % 4]}};
            f.c_here   = (i & 1) ? 16'hFFFF : 16'd1;
            f.rho_here = (i & 2) ? 16'hFFFF : 16'd1;
            f.c_nb     = (i & 4) ? 16'hFFFF : 16'd1;
            f.rho_nb   = (i & 8) ? 16'hFFFF : 16'd1;
            f.interior = i[0] ^ i[2];
            send_face(f);
        end
    endtask

    task automatic test_boundary_faces();
        t_face f;
        for (int i = 0; i < 6; i++) begin
            f          = rand_face();
            f.interior = 1'b0;
            if (i == 0) begin
                f.p_minus = 16'sd0;
            end
            send_face(f);
        end
        f        = rand_face();
        f.p_plus = f.p_minus;
        f.u_plus = f.u_minus;
        f.interior = 1'b1;
        send_face(f);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            send_face(rand_face());
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= $urandom_range(99) < recv_idle_pct;
    end

    always @(posedge i_clk) begin
        t_flux e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (flux_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result at %0t", $realtime);
                end
            end else begin
                e = flux_queue.pop_front();
                if (o_pressure_flux !== e.p_flux || o_flux_x !== e.fx
                        || o_flux_y !== e.fy || o_flux_z !== e.fz) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t: expected p=%h x=%h y=%h z=%h got p=%h x=%h y=%h z=%h",
                                 $realtime, e.p_flux, e.fx, e.fy, e.fz,
                                 o_pressure_flux, o_flux_x, o_flux_y, o_flux_z);
                    end
                end
            end
        end
    end

    initial begin
        #3ms;
        $display("acoustic_upwind_face_flux test failed");
        $finish;
    end

    initial begin
        mismatches           = 0;
        send_idle_pct        = 37;
        recv_idle_pct        = 57;
        i_rst_n              = 1'b0;
        i_valid              = 1'b0;
        i_stall              = 1'b0;
        i_pressure_minus     = '0;
        i_velocity_minus_xyz = '0;
        i_pressure_plus      = '0;
        i_velocity_plus_xyz  = '0;
        i_normal_xyz         = '0;
        i_speed_here         = 16'd1;
        i_density_here       = 16'd1;
        i_speed_neighbour    = 16'd1;
        i_density_neighbour  = 16'd1;
        i_has_neighbour      = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_boundary_faces();
        test_random(230);
        send_idle_pct = 57;
        recv_idle_pct = 37;
        test_random(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(250);
        i_valid <= 1'b0;
        while (flux_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (80) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("acoustic_upwind_face_flux test passed");
        end else begin
            $display("acoustic_upwind_face_flux test failed");
        end
        $finish;
    end
endmodule
